/* hw/rtl/segment_box_slab_intersection_macros.svh */
// ----------------------------------------------------------------------------
// Segment/box slab intersection - assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_SLAB_INTERSECTION_MACROS_SVH
`define SEGMENT_BOX_SLAB_INTERSECTION_MACROS_SVH

`ifndef ASSERT_OFF

// Plain property, checked at every rising edge outside of reset.
`define SBSI_ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SBSI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  `SBSI_ASSERT_PROP(label, clk, rst_n, (ante) |-> (cons), msg)

`else

`define SBSI_ASSERT_PROP(label, clk, rst_n, prop, msg)

`define SBSI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/sbsi_pkg.sv */
// ----------------------------------------------------------------------------
// Segment/box slab intersection - shared package
// Default widths, register indexes and the normal magnitude table.
// ----------------------------------------------------------------------------
package sbsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_AXES        = 3;
  localparam int TOL_WIDTH       = 16;
  localparam int NORM_WIDTH      = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_LOW_X  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_LOW_Y  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_LOW_Z  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_HIGH_X = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_HIGH_Y = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_HIGH_Z = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE  = 3'd6;

  // Q1.14 component magnitude of a unit vector with k equal nonzero parts.
  function automatic logic signed [NORM_WIDTH-1:0] norm_unit(input logic [1:0] k);
    logic signed [NORM_WIDTH-1:0] u;
    case (k)
      2'd1:    u = 16'sd16384;
      2'd2:    u = 16'sd11585;
      2'd3:    u = 16'sd9459;
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

/* hw/rtl/sbsi_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Segment/box slab intersection - configuration registers
// Box bounds and tolerance, written through the cfg channel.
// ----------------------------------------------------------------------------
module sbsi_cfg_regs #(
  parameter int COORD_WIDTH = sbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       wr_en,
  input  logic [sbsi_pkg::CFG_INDEX_WIDTH-1:0]       wr_index,
  input  logic [COORD_WIDTH-1:0]                     wr_data,
  output logic signed [COORD_WIDTH-1:0]              box_lo [sbsi_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0]              box_hi [sbsi_pkg::NUM_AXES],
  output logic [sbsi_pkg::TOL_WIDTH-1:0]             tol
);
  import sbsi_pkg::*;

  localparam logic signed [COORD_WIDTH-1:0] ONE_FX = COORD_WIDTH'(1) << FRAC_BITS;

  logic signed [COORD_WIDTH-1:0] box_lo_r [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] box_hi_r [NUM_AXES];
  logic [TOL_WIDTH-1:0]          tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        box_lo_r[i] <= -ONE_FX;
        box_hi_r[i] <= ONE_FX;
      end
      tol_r <= TOL_WIDTH'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_BOX_LOW_X:  box_lo_r[0] <= wr_data;
        REG_BOX_LOW_Y:  box_lo_r[1] <= wr_data;
        REG_BOX_LOW_Z:  box_lo_r[2] <= wr_data;
        REG_BOX_HIGH_X: box_hi_r[0] <= wr_data;
        REG_BOX_HIGH_Y: box_hi_r[1] <= wr_data;
        REG_BOX_HIGH_Z: box_hi_r[2] <= wr_data;
        REG_TOLERANCE:  tol_r       <= wr_data[TOL_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  assign box_lo = box_lo_r;
  assign box_hi = box_hi_r;
  assign tol    = tol_r;

endmodule

/* hw/rtl/sbsi_delay.sv */
// ----------------------------------------------------------------------------
// Segment/box slab intersection - payload delay line
// Fixed-depth shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module sbsi_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);
  import sbsi_pkg::*;

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

/* hw/rtl/sbsi_slab_div.sv */
// ----------------------------------------------------------------------------
// Segment/box slab intersection - pipelined slab divider
// Saturating magnitude divide, one quotient bit per stage, sign at the end.
// ----------------------------------------------------------------------------
module sbsi_slab_div #(
  parameter int W = 33,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic [W-1:0]        num_mag,
  input  logic [W-1:0]        den_mag,
  input  logic                neg,
  output logic signed [F+2:0] t_q
);
  import sbsi_pkg::*;

  logic [W-1:0] un_r, ud_r;
  logic         neg_r;

  logic [W-1:0] rem_r [F+1];
  logic [W-1:0] den_r [F+1];
  logic [F:0]   quo_r [F+1];
  logic         sat_r [F+1];
  logic         sgn_r [F+1];
  logic signed [F+2:0] t_r;

  logic         sat0, q0;
  logic [W-1:0] rem0;

  always_ff @(posedge clk) begin
    un_r  <= num_mag;
    ud_r  <= den_mag;
    neg_r <= neg;
  end

  // Integer bit: the quotient is below two unless it saturates.
  always_comb begin
    sat0 = {1'b0, un_r} >= {ud_r, 1'b0};
    q0   = un_r >= ud_r;
    rem0 = q0 ? (un_r - ud_r) : un_r;
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= rem0;
    den_r[0] <= ud_r;
    quo_r[0] <= (F+1)'(q0);
    sat_r[0] <= sat0;
    sgn_r[0] <= neg_r;
  end

  for (genvar j = 1; j <= F; j++) begin : g_frac
    logic [W:0] r2, diff;
    logic       ge;
    always_comb begin
      r2   = {rem_r[j-1], 1'b0};
      diff = r2 - {1'b0, den_r[j-1]};
      ge   = r2 >= {1'b0, den_r[j-1]};
    end
    always_ff @(posedge clk) begin
      rem_r[j] <= ge ? diff[W-1:0] : r2[W-1:0];
      den_r[j] <= den_r[j-1];
      quo_r[j] <= {quo_r[j-1][F-1:0], ge};
      sat_r[j] <= sat_r[j-1];
      sgn_r[j] <= sgn_r[j-1];
    end
  end

  logic [F+1:0]        tmag;
  logic signed [F+2:0] tpos;

  always_comb begin
    tmag = sat_r[F] ? {1'b1, {(F+1){1'b0}}} : {1'b0, quo_r[F]};
    tpos = $signed({1'b0, tmag});
  end

  always_ff @(posedge clk) begin
    t_r <= sgn_r[F] ? -tpos : tpos;
  end

  assign t_q = t_r;

endmodule

/* hw/rtl/sbsi_point.sv */
// ----------------------------------------------------------------------------
// Segment/box slab intersection - entry point and face normal
// Scales the direction by tmin, adds the start and marks faces in tolerance.
// ----------------------------------------------------------------------------
module sbsi_point #(
  parameter int COORD_WIDTH = sbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  logic                                 in_hit,
  input  logic [FRAC_BITS:0]                   in_tmin,
  input  logic signed [COORD_WIDTH-1:0]        in_s [sbsi_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH:0]          in_d [sbsi_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]        box_lo [sbsi_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]        box_hi [sbsi_pkg::NUM_AXES],
  input  logic [sbsi_pkg::TOL_WIDTH-1:0]       tol,
  output logic                                 out_vld,
  output logic                                 out_hit,
  output logic [FRAC_BITS:0]                   out_tmin,
  output logic signed [COORD_WIDTH-1:0]        out_p [sbsi_pkg::NUM_AXES],
  output logic signed [sbsi_pkg::NORM_WIDTH-1:0] out_n [sbsi_pkg::NUM_AXES]
);
  import sbsi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int W  = CW + 1;
  localparam int PW = CW + F + 3;
  localparam int XW = CW + TOL_WIDTH + 1;

  // Stage 1: product d * tmin.
  logic                 v1_r, h1_r;
  logic [F:0]           t1_r;
  logic signed [CW-1:0] s1_r [NUM_AXES];
  logic signed [PW-1:0] prod_r [NUM_AXES];
  // Stage 2: entry point.
  logic                 v2_r, h2_r;
  logic [F:0]           t2_r;
  logic signed [CW-1:0] p2_r [NUM_AXES];
  // Stage 3: distances to both faces.
  logic                 v3_r, h3_r;
  logic [F:0]           t3_r;
  logic signed [CW-1:0] p3_r [NUM_AXES];
  logic signed [W-1:0]  dlo_r [NUM_AXES];
  logic signed [W-1:0]  dhi_r [NUM_AXES];
  // Stage 4: result.
  logic                 v4_r, h4_r;
  logic [F:0]           t4_r;
  logic signed [CW-1:0] p4_r [NUM_AXES];
  logic signed [NORM_WIDTH-1:0] n4_r [NUM_AXES];

  logic signed [F+1:0] tmin_s;
  assign tmin_s = $signed({1'b0, in_tmin});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    h1_r <= in_hit;
    t1_r <= in_tmin;
    h2_r <= h1_r;
    t2_r <= t1_r;
    h3_r <= h2_r;
    t3_r <= t2_r;
    for (int i = 0; i < NUM_AXES; i++) begin
      s1_r[i]   <= in_s[i];
      prod_r[i] <= PW'(in_d[i]) * PW'(tmin_s);
      p2_r[i]   <= CW'(PW'(s1_r[i]) + (prod_r[i] >>> F));
      p3_r[i]   <= p2_r[i];
      dlo_r[i]  <= W'(p2_r[i]) - W'(box_lo[i]);
      dhi_r[i]  <= W'(p2_r[i]) - W'(box_hi[i]);
    end
  end

  logic [W-1:0]  mlo [NUM_AXES];
  logic [W-1:0]  mhi [NUM_AXES];
  logic          at_lo [NUM_AXES];
  logic          at_hi [NUM_AXES];
  logic [1:0]    k;
  logic signed [NORM_WIDTH-1:0] unit;

  always_comb begin
    k = 2'd0;
    for (int i = 0; i < NUM_AXES; i++) begin
      mlo[i]   = dlo_r[i][W-1] ? W'(-dlo_r[i]) : W'(dlo_r[i]);
      mhi[i]   = dhi_r[i][W-1] ? W'(-dhi_r[i]) : W'(dhi_r[i]);
      at_lo[i] = XW'(mlo[i]) <= XW'(tol);
      at_hi[i] = !at_lo[i] && (XW'(mhi[i]) <= XW'(tol));
      k        = k + 2'((at_lo[i] || at_hi[i]) ? 1 : 0);
    end
    unit = norm_unit(k);
  end

  always_ff @(posedge clk) begin
    h4_r <= h3_r;
    t4_r <= h3_r ? t3_r : '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      p4_r[i] <= h3_r ? p3_r[i] : '0;
      if (!h3_r) begin
        n4_r[i] <= '0;
      end else if (at_lo[i]) begin
        n4_r[i] <= -unit;
      end else if (at_hi[i]) begin
        n4_r[i] <= unit;
      end else begin
        n4_r[i] <= '0;
      end
    end
  end

  assign out_vld  = v4_r;
  assign out_hit  = h4_r;
  assign out_tmin = t4_r;
  assign out_p    = p4_r;
  assign out_n    = n4_r;

endmodule

/* hw/rtl/segment_box_slab_intersection.sv */
// ----------------------------------------------------------------------------
// Segment/box slab intersection - top level
// Slab test of a segment against a configurable axis-aligned box.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Beat taken when
//   --------  ---------------------------  ------------------------------
//   input     start, busy, in_*            start high and busy low
//   result    out_strobe, out_*            out_strobe high (one cycle)
//   config    cfg_valid, cfg_ready, cfg_*  cfg_valid and cfg_ready high
//
// One segment enters every clock cycle; busy is never raised.
// Each segment passes the capture stage, the slab dividers, which retire
// one quotient bit per stage, the interval stages and the point unit.
// Reset is synchronous and active low; it clears the valid bits of all
// stages and loads the default box (-1..+1 on each axis, tolerance 2^-16).
// The receiver cannot stall, so the pipeline never holds.
//
`include "segment_box_slab_intersection_macros.svh"

module segment_box_slab_intersection #(
  parameter int COORD_WIDTH = sbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [COORD_WIDTH-1:0]           in_start_x,
  input  logic signed [COORD_WIDTH-1:0]           in_start_y,
  input  logic signed [COORD_WIDTH-1:0]           in_start_z,
  input  logic signed [COORD_WIDTH-1:0]           in_end_x,
  input  logic signed [COORD_WIDTH-1:0]           in_end_y,
  input  logic signed [COORD_WIDTH-1:0]           in_end_z,
  output logic                                    out_strobe,
  output logic                                    out_hit,
  output logic [FRAC_BITS:0]                      out_entry_param,
  output logic signed [COORD_WIDTH-1:0]           out_point_x,
  output logic signed [COORD_WIDTH-1:0]           out_point_y,
  output logic signed [COORD_WIDTH-1:0]           out_point_z,
  output logic signed [sbsi_pkg::NORM_WIDTH-1:0]  out_normal_x,
  output logic signed [sbsi_pkg::NORM_WIDTH-1:0]  out_normal_y,
  output logic signed [sbsi_pkg::NORM_WIDTH-1:0]  out_normal_z,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [sbsi_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]                  cfg_data
);
  import sbsi_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int F       = FRAC_BITS;
  localparam int W       = CW + 1;      // differences of two coordinates
  localparam int TW      = F + 3;       // signed slab parameter, up to +-2.0
  localparam int XW      = CW + TOL_WIDTH + 1;
  localparam int DIV_LAT = F + 3;       // operand, integer, F fraction, sign
  localparam int SIDE_W  = NUM_AXES * (CW + W);
  localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< F;

  // Both sides of the block always accept.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // Configuration. Writes must arrive only while the pipeline is empty;
  // the block does not enforce it. Stages read the live registers, not copies.
  // ---------------------------------------------------------------------
  logic signed [CW-1:0]  box_lo [NUM_AXES];
  logic signed [CW-1:0]  box_hi [NUM_AXES];
  logic [TOL_WIDTH-1:0]  tol;

  sbsi_cfg_regs #(
    .COORD_WIDTH (CW),
    .FRAC_BITS   (F)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .box_lo   (box_lo),
    .box_hi   (box_hi),
    .tol      (tol)
  );

  // ---------------------------------------------------------------------
  // Stage 0: capture the segment and form the direction and the distances
  // from the start to both planes of every slab.
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] in_s [NUM_AXES];
  logic signed [CW-1:0] in_e [NUM_AXES];

  assign in_s[0] = in_start_x;
  assign in_s[1] = in_start_y;
  assign in_s[2] = in_start_z;
  assign in_e[0] = in_end_x;
  assign in_e[1] = in_end_y;
  assign in_e[2] = in_end_z;

  logic                 v0_r;
  logic signed [CW-1:0] s0_r   [NUM_AXES];
  logic signed [W-1:0]  d0_r   [NUM_AXES];
  logic signed [W-1:0]  nlo0_r [NUM_AXES];
  logic signed [W-1:0]  nhi0_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      s0_r[i]   <= in_s[i];
      d0_r[i]   <= W'(in_e[i]) - W'(in_s[i]);
      nlo0_r[i] <= W'(box_lo[i]) - W'(in_s[i]);
      nhi0_r[i] <= W'(box_hi[i]) - W'(in_s[i]);
    end
  end

  // ---------------------------------------------------------------------
  // Magnitudes and signs go to the dividers. An axis whose direction is
  // shorter than the tolerance is parallel: it takes no part in the
  // interval and misses outright when the start lies outside its slab.
  // ---------------------------------------------------------------------
  logic [NUM_AXES-1:0]  par0, pmiss0;
  logic signed [TW-1:0] t_lo [NUM_AXES];
  logic signed [TW-1:0] t_hi [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic [W-1:0] ud, ulo, uhi;
    always_comb begin
      ud        = d0_r[a][W-1]   ? W'(-d0_r[a])   : W'(d0_r[a]);
      ulo       = nlo0_r[a][W-1] ? W'(-nlo0_r[a]) : W'(nlo0_r[a]);
      uhi       = nhi0_r[a][W-1] ? W'(-nhi0_r[a]) : W'(nhi0_r[a]);
      par0[a]   = XW'(ud) < XW'(tol);
      pmiss0[a] = par0[a] && ((s0_r[a] < box_lo[a]) || (s0_r[a] > box_hi[a]));
    end

    sbsi_slab_div #(.W(W), .F(F)) u_div_lo (
      .clk     (clk),
      .num_mag (ulo),
      .den_mag (ud),
      .neg     (nlo0_r[a][W-1] ^ d0_r[a][W-1]),
      .t_q     (t_lo[a])
    );

    sbsi_slab_div #(.W(W), .F(F)) u_div_hi (
      .clk     (clk),
      .num_mag (uhi),
      .den_mag (ud),
      .neg     (nhi0_r[a][W-1] ^ d0_r[a][W-1]),
      .t_q     (t_hi[a])
    );
  end

  // Valid bits follow the dividers stage by stage.
  logic [DIV_LAT-1:0] vdiv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdiv_r <= '0;
    end else begin
      vdiv_r <= {vdiv_r[DIV_LAT-2:0], v0_r};
    end
  end

  // Parallel flags meet the quotients; start and direction travel on to
  // the point unit, two interval stages further.
  logic [2*NUM_AXES-1:0] flags_dly;
  logic [SIDE_W-1:0]     side_in, side_dly;

  sbsi_delay #(.WIDTH(2*NUM_AXES), .DEPTH(DIV_LAT)) u_flag_dly (
    .clk  (clk),
    .din  ({par0, pmiss0}),
    .dout (flags_dly)
  );

  assign side_in = {s0_r[2], s0_r[1], s0_r[0], d0_r[2], d0_r[1], d0_r[0]};

  sbsi_delay #(.WIDTH(SIDE_W), .DEPTH(DIV_LAT + 2)) u_side_dly (
    .clk  (clk),
    .din  (side_in),
    .dout (side_dly)
  );

  logic signed [CW-1:0] s_pt [NUM_AXES];
  logic signed [W-1:0]  d_pt [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_unpack
    assign d_pt[a] = side_dly[a*W +: W];
    assign s_pt[a] = side_dly[NUM_AXES*W + a*CW +: CW];
  end

  // ---------------------------------------------------------------------
  // Interval stage 1: order the two slab parameters of each axis.
  // ---------------------------------------------------------------------
  logic                 v1_r, pm1_r;
  logic [NUM_AXES-1:0]  par1_r;
  logic signed [TW-1:0] near1_r [NUM_AXES];
  logic signed [TW-1:0] far1_r  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= vdiv_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    par1_r <= flags_dly[2*NUM_AXES-1:NUM_AXES];
    pm1_r  <= |flags_dly[NUM_AXES-1:0];
    for (int i = 0; i < NUM_AXES; i++) begin
      near1_r[i] <= (t_lo[i] > t_hi[i]) ? t_hi[i] : t_lo[i];
      far1_r[i]  <= (t_lo[i] > t_hi[i]) ? t_lo[i] : t_hi[i];
    end
  end

  // ---------------------------------------------------------------------
  // Interval stage 2: clip [0,1] by every non-parallel slab. The interval
  // only shrinks, so the miss is one emptiness check at the end or a parallel miss.
  // ---------------------------------------------------------------------
  logic signed [TW-1:0] tmin, tmax;
  logic                 miss;

  always_comb begin
    tmin = '0;
    tmax = T_ONE;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (!par1_r[i]) begin
        if (near1_r[i] > tmin) tmin = near1_r[i];
        if (far1_r[i] < tmax)  tmax = far1_r[i];
      end
    end
    miss = pm1_r || (tmin > tmax);
  end

  logic       v2_r, hit2_r;
  logic [F:0] tmin2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  // On a hit tmin lies in [0,1] and fits F+1 unsigned bits.
  always_ff @(posedge clk) begin
    hit2_r  <= !miss;
    tmin2_r <= tmin[F:0];
  end

  // ---------------------------------------------------------------------
  // Entry point, face marks and normal, four stages.
  // ---------------------------------------------------------------------
  logic [F:0]                   res_tmin;
  logic signed [CW-1:0]         res_p [NUM_AXES];
  logic signed [NORM_WIDTH-1:0] res_n [NUM_AXES];

  sbsi_point #(
    .COORD_WIDTH (CW),
    .FRAC_BITS   (F)
  ) u_point (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v2_r),
    .in_hit   (hit2_r),
    .in_tmin  (tmin2_r),
    .in_s     (s_pt),
    .in_d     (d_pt),
    .box_lo   (box_lo),
    .box_hi   (box_hi),
    .tol      (tol),
    .out_vld  (out_strobe),
    .out_hit  (out_hit),
    .out_tmin (res_tmin),
    .out_p    (res_p),
    .out_n    (res_n)
  );

  assign out_entry_param = res_tmin;
  assign out_point_x     = res_p[0];
  assign out_point_y     = res_p[1];
  assign out_point_z     = res_p[2];
  assign out_normal_x    = res_n[0];
  assign out_normal_y    = res_n[1];
  assign out_normal_z    = res_n[2];

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `SBSI_ASSERT_IMPLY(a_miss_clears, clk, rst_n,
    out_strobe && !out_hit,
    out_entry_param == '0 && out_point_x == '0 && out_point_y == '0 &&
    out_point_z == '0 && out_normal_x == '0 && out_normal_y == '0 &&
    out_normal_z == '0,
    "missed segment carries nonzero result fields")

  `SBSI_ASSERT_IMPLY(a_entry_in_range, clk, rst_n,
    out_strobe && out_hit,
    out_entry_param <= (F+1)'(1) << F,
    "entry parameter above one on a hit")

  `SBSI_ASSERT_PROP(a_normal_equal, clk, rst_n,
    (out_strobe && out_normal_x != '0 && out_normal_y != '0) |->
    (out_normal_x == out_normal_y || out_normal_x == -out_normal_y),
    "normal components differ in magnitude")

endmodule
